@@ rtl/rle_run_literal_decoder_assert.svh @@
// Assertion macros shared by the run/literal decoder RTL.
`ifndef RLE_RUN_LITERAL_DECODER_ASSERT_SVH
`define RLE_RUN_LITERAL_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RLD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rld assertion failed");

// Next-cycle implication, disabled during reset
`define RLD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rld assertion failed");

`endif

@@ rtl/rld_pkg.sv @@
// Shared types and constants of the run/literal decoder.
package rld_pkg;

  // Width of the pixel total and of the pixel target register
  localparam int PIXEL_COUNT_BITS = 44;
  localparam int COUNT_BITS       = 15;

  typedef logic [PIXEL_COUNT_BITS-1:0] pixel_count_t;
  typedef logic [COUNT_BITS-1:0]       run_count_t;

  // Long tokens carry count - 64
  localparam run_count_t LEN_OFFSET = 15'd64;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ZERO       = 3'd1;
  localparam logic [2:0] ST_OVERFLOW   = 3'd2;
  localparam logic [2:0] ST_TRUNC      = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;

  // One result beat
  typedef struct packed {
    logic [7:0] pixel_value;
    run_count_t repeat_count;
    logic [2:0] status;
    logic       channel_end;
  } result_t;

endpackage

@@ rtl/rle_run_literal_decoder.sv @@
// Top level of the run/literal byte-stream decoder.
//
//  channel | direction | beat contents
//  --------+-----------+----------------------------------------------------------
//  s_*     | in        | tdata[7:0] stream_byte, tlast stream_last
//  m_*     | out       | tdata[7:0] pixel_value, [22:8] repeat_count; tuser status;
//          |           | tlast channel_end
//  cfg_*   | in        | cfg_wdata pixel target, written when cfg_we is high
//
// One byte per cycle sustained while m_tready stays high; a byte is held in the input
// register and its result is then loaded into the output register, set by the
// state update (pixel total add and compare against the pixel target).
// Synchronous rst clears both valid flags, the decode state and the pixel target.
// With m_tready low the result holds, one more byte is taken into the input
// register, then s_tready falls until the result drains.
module rle_run_literal_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  rld_pkg::pixel_count_t cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] stream_byte
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [7:0] pixel_value, [22:8] repeat_count, [23] 0
  output logic [2:0]            m_tuser,   // [2:0] status
  output logic                  m_tlast
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_last;
  logic             free;
  logic             fire;
  logic             emit;
  rld_pkg::result_t result;

  // Decode step runs when a byte is held and the result slot is free
  assign fire     = in_valid && free;
  assign s_tready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  rld_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .emit      (emit),
    .result    (result)
  );

  rld_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && emit),
    .result   (result),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ rtl/rld_decode.sv @@
// Token state machine, pixel accounting and result formation for one byte.
`include "rle_run_literal_decoder_assert.svh"

module rld_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  rld_pkg::pixel_count_t cfg_wdata,
  input  logic                  fire,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  emit,
  output rld_pkg::result_t      result
);

  localparam int PW = rld_pkg::PIXEL_COUNT_BITS;

  // Phase codes
  localparam logic [2:0] PH_CTRL    = 3'd0;
  localparam logic [2:0] PH_LOW     = 3'd1;
  localparam logic [2:0] PH_VALUE   = 3'd2;
  localparam logic [2:0] PH_LITDATA = 3'd3;
  localparam logic [2:0] PH_DISCARD = 3'd4;

  logic [2:0]            phase, phase_next;
  logic                  token_is_literal, token_is_literal_next;
  logic [5:0]            count_high_bits, count_high_bits_next;
  rld_pkg::run_count_t   remaining_count, remaining_count_next;
  rld_pkg::pixel_count_t pixels_written, pixels_written_next;
  logic [2:0]            first_error, first_error_next;
  rld_pkg::pixel_count_t pixel_target;

  logic [2:0]            err;
  logic                  produce;
  rld_pkg::run_count_t   cnt_long;
  rld_pkg::run_count_t   chk_count;
  rld_pkg::run_count_t   rem_dec;
  logic [PW:0]           chk_sum;
  logic                  ovf;

  // Long count and the single overflow check shared by the control, low-count and value phases
  assign cnt_long = rld_pkg::run_count_t'({count_high_bits, in_byte}) + rld_pkg::LEN_OFFSET;

  always_comb begin
    case (phase)
      PH_CTRL: chk_count = rld_pkg::run_count_t'(in_byte[5:0]);
      PH_LOW:  chk_count = cnt_long;
      default: chk_count = remaining_count;
    endcase
  end

  assign chk_sum = {1'b0, pixels_written} + (PW+1)'(chk_count);
  assign ovf     = chk_sum > {1'b0, pixel_target};
  assign rem_dec = (remaining_count != '0) ? remaining_count - 15'd1 : remaining_count;

  // Next state and result
  always_comb begin
    phase_next            = phase;
    token_is_literal_next = token_is_literal;
    count_high_bits_next  = count_high_bits;
    remaining_count_next  = remaining_count;
    pixels_written_next   = pixels_written;
    first_error_next      = first_error;
    err                   = rld_pkg::ST_OK;
    produce               = 1'b0;
    result.pixel_value    = 8'd0;
    result.repeat_count   = '0;
    result.status         = rld_pkg::ST_OK;
    result.channel_end    = in_last;

    case (phase)
      PH_CTRL: begin
        token_is_literal_next = in_byte[7];
        if (!in_byte[6]) begin
          if (in_byte[5:0] == 6'd0) begin
            err = rld_pkg::ST_ZERO;
          end else if (in_last) begin
            err = rld_pkg::ST_TRUNC;
          end else begin
            remaining_count_next = rld_pkg::run_count_t'(in_byte[5:0]);
            if (in_byte[7]) begin
              if (ovf) err = rld_pkg::ST_OVERFLOW;
              else     phase_next = PH_LITDATA;
            end else begin
              phase_next = PH_VALUE;
            end
          end
        end else begin
          count_high_bits_next = in_byte[5:0];
          phase_next           = PH_LOW;
          if (in_last) err = rld_pkg::ST_TRUNC;
        end
      end
      PH_LOW: begin
        remaining_count_next = cnt_long;
        if (in_last) begin
          err = rld_pkg::ST_TRUNC;
        end else if (token_is_literal) begin
          if (ovf) err = rld_pkg::ST_OVERFLOW;
          else     phase_next = PH_LITDATA;
        end else begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (ovf) begin
          err = rld_pkg::ST_OVERFLOW;
        end else begin
          result.pixel_value   = in_byte;
          result.repeat_count  = remaining_count;
          pixels_written_next  = pixels_written + PW'(remaining_count);
          remaining_count_next = '0;
          phase_next           = PH_CTRL;
          produce              = 1'b1;
        end
      end
      PH_LITDATA: begin
        if ((remaining_count > 15'd1) && in_last) begin
          err = rld_pkg::ST_TRUNC;
        end else begin
          result.pixel_value   = in_byte;
          result.repeat_count  = 15'd1;
          pixels_written_next  = pixels_written + PW'(1);
          remaining_count_next = rem_dec;
          if (rem_dec == '0) phase_next = PH_CTRL;
          produce              = 1'b1;
        end
      end
      PH_DISCARD: begin
        phase_next = PH_DISCARD;
      end
      default: begin
        phase_next = PH_DISCARD;
      end
    endcase

    // Error, end-of-channel and plain results
    if (err != rld_pkg::ST_OK) begin
      if (first_error == rld_pkg::ST_OK) first_error_next = err;
      result.status       = err;
      result.pixel_value  = 8'd0;
      result.repeat_count = '0;
      phase_next          = PH_DISCARD;
      emit                = 1'b1;
    end else if (in_last) begin
      if (phase == PH_DISCARD) begin
        result.status       = first_error;
        result.pixel_value  = 8'd0;
        result.repeat_count = '0;
      end else begin
        result.status = (pixels_written_next == pixel_target) ?
                        rld_pkg::ST_OK : rld_pkg::ST_INCOMPLETE;
      end
      emit = 1'b1;
    end else begin
      emit = produce;
    end

    // Last byte starts a fresh channel
    if (in_last) begin
      phase_next            = PH_CTRL;
      token_is_literal_next = 1'b0;
      count_high_bits_next  = 6'd0;
      remaining_count_next  = '0;
      pixels_written_next   = '0;
      first_error_next      = rld_pkg::ST_OK;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_CTRL;
      token_is_literal <= 1'b0;
      count_high_bits  <= 6'd0;
      remaining_count  <= '0;
      pixels_written   <= '0;
      first_error      <= rld_pkg::ST_OK;
    end else if (fire) begin
      phase            <= phase_next;
      token_is_literal <= token_is_literal_next;
      count_high_bits  <= count_high_bits_next;
      remaining_count  <= remaining_count_next;
      pixels_written   <= pixels_written_next;
      first_error      <= first_error_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_target <= '0;
    end else if (cfg_we) begin
      pixel_target <= cfg_wdata;
    end
  end

  // Discarding exactly when an error is held
  `RLD_ASSERT_IMP(a_discard_err, clk, rst, 1'b1,
                  (phase == PH_DISCARD) == (first_error != rld_pkg::ST_OK))
  // Mid-stream error results carry no pixels
  `RLD_ASSERT_IMP(a_err_empty, clk, rst,
                  fire && emit && !in_last && (result.status != rld_pkg::ST_OK),
                  (result.repeat_count == '0) && (result.pixel_value == 8'd0))
  // A last byte always closes the channel with a result and a clean state
  `RLD_ASSERT_NXT(a_last_clear, clk, rst, fire && in_last,
                  (phase == PH_CTRL) && (pixels_written == '0) && $past(emit))

endmodule

@@ rtl/rld_out_reg.sv @@
// Result register on the master side of the decoder.
module rld_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rld_pkg::result_t result,
  output logic             free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,
  output logic [2:0]       m_tuser,
  output logic             m_tlast
);

  rld_pkg::result_t held;

  // Slot can take a new result when empty or being drained this cycle
  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= result;
  end

  assign m_tdata = {1'b0, held.repeat_count, held.pixel_value};
  assign m_tuser = held.status;
  assign m_tlast = held.channel_end;

endmodule

@@ verif/rle_run_literal_decoder_tb.sv @@
// Self-checking testbench for the run/literal byte-stream decoder.
`timescale 1ns / 1ps

module rle_run_literal_decoder_tb;

  // Decoder phases of the predictor
  typedef enum logic [2:0] {
    DEC_CTRL, DEC_LOW, DEC_VALUE, DEC_LITDATA, DEC_DISCARD
  } dec_phase_t;

  // Directed table rows: a register write or one stream beat
  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [7:0]            data;
    logic                  last;
    logic                  typed;   // want holds the result as read off the format
    rld_pkg::result_t      want;
    rld_pkg::pixel_count_t cfg;
  } stim_row_t;

  localparam rld_pkg::result_t      NO_RES   = '0;
  localparam rld_pkg::pixel_count_t PIX_NONE = '0;
  localparam rld_pkg::pixel_count_t PIX_MAX  = '1;
  localparam int                    N_ROWS   = 31;
  localparam int                    N_ITEMS  = 650;
  localparam int                    IDLE_PCT = 38;
  localparam int                    SETTLE   = 8;   // cycles for beats with no result
  localparam int                    HOLD_LEN = 60;

  // Directed stimulus: reset value, short and long tokens, every status
  localparam stim_row_t directed_rows [0:N_ROWS-1] = '{
    // pixel target still at reset: zero count, discard, truncated run
    '{ROW_BYTE, 8'h00, 1'b0, 1'b1, '{8'h00, 15'd0, rld_pkg::ST_ZERO, 1'b0}, PIX_NONE},
    '{ROW_BYTE, 8'h55, 1'b1, 1'b1, '{8'h00, 15'd0, rld_pkg::ST_ZERO, 1'b1}, PIX_NONE},
    '{ROW_BYTE, 8'h01, 1'b1, 1'b1, '{8'h00, 15'd0, rld_pkg::ST_TRUNC, 1'b1}, PIX_NONE},
    // exact fit of runs and literals
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, NO_RES, 44'd5},
    '{ROW_BYTE, 8'h02, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'h81, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'h82, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'hAB, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'hCD, 1'b1, 1'b0, NO_RES, PIX_NONE},
    // largest long run, then a long literal cut off by the last beat
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, NO_RES, PIX_MAX},
    '{ROW_BYTE, 8'h7F, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b1, '{8'h00, 15'd16447, rld_pkg::ST_OK, 1'b0}, PIX_NONE},
    '{ROW_BYTE, 8'hC0, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'h99, 1'b1, 1'b1, '{8'h00, 15'd0, rld_pkg::ST_TRUNC, 1'b1}, PIX_NONE},
    // long run whose low count beat is the last
    '{ROW_BYTE, 8'h7F, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'h10, 1'b1, 1'b1, '{8'h00, 15'd0, rld_pkg::ST_TRUNC, 1'b1}, PIX_NONE},
    // literal overflow, then truncation winning when the count lands on last
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'h81, 1'b0, 1'b1, '{8'h00, 15'd0, rld_pkg::ST_OVERFLOW, 1'b0}, PIX_NONE},
    '{ROW_BYTE, 8'h12, 1'b1, 1'b1, '{8'h00, 15'd0, rld_pkg::ST_OVERFLOW, 1'b1}, PIX_NONE},
    '{ROW_BYTE, 8'hC5, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, '{8'h00, 15'd0, rld_pkg::ST_TRUNC, 1'b1}, PIX_NONE},
    // short of the total, run overflow on its value beat, zero literal count
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, NO_RES, 44'd10},
    '{ROW_BYTE, 8'h01, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'h07, 1'b1, 1'b1, '{8'h07, 15'd1, rld_pkg::ST_INCOMPLETE, 1'b1}, PIX_NONE},
    '{ROW_BYTE, 8'h3F, 1'b0, 1'b0, NO_RES, PIX_NONE},
    '{ROW_BYTE, 8'h80, 1'b1, 1'b1, '{8'h00, 15'd0, rld_pkg::ST_OVERFLOW, 1'b1}, PIX_NONE},
    '{ROW_BYTE, 8'h80, 1'b1, 1'b1, '{8'h00, 15'd0, rld_pkg::ST_ZERO, 1'b1}, PIX_NONE}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  rld_pkg::pixel_count_t cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;
  logic [2:0]            m_tuser;
  logic                  m_tlast;

  // Predictor state
  dec_phase_t            dec_phase;
  logic                  lit_token;
  logic [5:0]            len_high;
  rld_pkg::run_count_t   run_left;
  rld_pkg::pixel_count_t pixels_done;
  logic [2:0]            first_err;
  rld_pkg::pixel_count_t exp_pixels;

  rld_pkg::result_t      pixel_results_q[$];
  logic [7:0]            chan_bytes[$];
  int unsigned           err_count   = 0;
  int unsigned           sent_beats  = 0;
  bit                    quiet       = 1'b0;
  int unsigned           stall_asks  = 0;
  int unsigned           stall_taken = 0;
  int unsigned           stall_left  = 0;
  rld_pkg::result_t      got_res;
  rld_pkg::result_t      want_res;

  rle_run_literal_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Overflow test: would count pixels pass the channel total?
  function automatic bit exceeds_total(input rld_pkg::run_count_t c);
    if (pixels_done > exp_pixels) return 1'b1;
    return rld_pkg::pixel_count_t'(c) > (exp_pixels - pixels_done);
  endfunction

  // Decode one accepted byte, returning the result it causes if any
  task automatic decode_byte(input logic [7:0] b, input bit last,
                             output bit emit, output rld_pkg::result_t r);
    logic [2:0]          err;
    logic [2:0]          status;
    logic [7:0]          val;
    rld_pkg::run_count_t cnt;
    bit                  produce;
    bit                  was_discard;
    err         = rld_pkg::ST_OK;
    val         = 8'h00;
    cnt         = '0;
    produce     = 1'b0;
    was_discard = (dec_phase == DEC_DISCARD);
    case (dec_phase)
      DEC_CTRL: begin
        lit_token = b[7];
        if (!b[6]) begin
          if (b[5:0] == 6'd0) err = rld_pkg::ST_ZERO;
          else if (last) err = rld_pkg::ST_TRUNC;
          else begin
            run_left = rld_pkg::run_count_t'(b[5:0]);
            if (lit_token) begin
              if (exceeds_total(run_left)) err = rld_pkg::ST_OVERFLOW;
              else dec_phase = DEC_LITDATA;
            end else begin
              dec_phase = DEC_VALUE;
            end
          end
        end else begin
          len_high  = b[5:0];
          dec_phase = DEC_LOW;
          if (last) err = rld_pkg::ST_TRUNC;
        end
      end
      DEC_LOW: begin
        run_left = rld_pkg::run_count_t'({len_high, b}) + rld_pkg::LEN_OFFSET;
        if (last) err = rld_pkg::ST_TRUNC;
        else if (lit_token) begin
          if (exceeds_total(run_left)) err = rld_pkg::ST_OVERFLOW;
          else dec_phase = DEC_LITDATA;
        end else begin
          dec_phase = DEC_VALUE;
        end
      end
      DEC_VALUE: begin
        if (exceeds_total(run_left)) err = rld_pkg::ST_OVERFLOW;
        else begin
          val         = b;
          cnt         = run_left;
          pixels_done = pixels_done + rld_pkg::pixel_count_t'(run_left);
          run_left    = '0;
          dec_phase   = DEC_CTRL;
          produce     = 1'b1;
        end
      end
      DEC_LITDATA: begin
        if (run_left > 15'd1 && last) err = rld_pkg::ST_TRUNC;
        else begin
          val         = b;
          cnt         = 15'd1;
          pixels_done = pixels_done + rld_pkg::pixel_count_t'(1);
          if (run_left != '0) run_left = run_left - 15'd1;
          if (run_left == '0) dec_phase = DEC_CTRL;
          produce     = 1'b1;
        end
      end
      default: dec_phase = DEC_DISCARD;
    endcase

    status = rld_pkg::ST_OK;
    emit   = 1'b0;
    if (err != rld_pkg::ST_OK) begin
      if (first_err == rld_pkg::ST_OK) first_err = err;
      status    = err;
      val       = 8'h00;
      cnt       = '0;
      dec_phase = DEC_DISCARD;
      emit      = 1'b1;
    end else if (last) begin
      if (was_discard) begin
        status = first_err;
        val    = 8'h00;
        cnt    = '0;
      end else begin
        status = (pixels_done == exp_pixels) ? rld_pkg::ST_OK : rld_pkg::ST_INCOMPLETE;
      end
      emit = 1'b1;
    end else if (produce) begin
      emit = 1'b1;
    end

    r.pixel_value  = val;
    r.repeat_count = cnt;
    r.status       = status;
    r.channel_end  = last;

    // Channel closed: start afresh, the register is kept
    if (last) begin
      dec_phase   = DEC_CTRL;
      lit_token   = 1'b0;
      len_high    = '0;
      run_left    = '0;
      pixels_done = '0;
      first_err   = rld_pkg::ST_OK;
    end
  endtask

  // Offer one beat with random gaps, predict it once accepted
  task automatic send_byte(input logic [7:0] b, input bit last,
                           input bit typed, input rld_pkg::result_t want);
    bit               emit;
    rld_pkg::result_t r;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_beats++;
    decode_byte(b, last, emit, r);
    if (typed) pixel_results_q.insert(pixel_results_q.size(), want);
    else if (emit) pixel_results_q.insert(pixel_results_q.size(), r);
  endtask

  // Stop sending and let every pending result drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pixel_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_expected(input rld_pkg::pixel_count_t v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    exp_pixels  = v;
  endtask

  // Build one channel: mostly well-formed tokens, some noise bytes
  task automatic random_channel(output rld_pkg::pixel_count_t total);
    int unsigned n_tok;
    int unsigned pick;
    int unsigned c;
    logic [5:0]  hi;
    logic [7:0]  lo;
    chan_bytes.delete();
    total = '0;
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        c = $urandom_range(1, 63);
        chan_bytes.insert(chan_bytes.size(), {2'b00, 6'(c)});
        chan_bytes.insert(chan_bytes.size(), 8'($urandom));
        total = total + rld_pkg::pixel_count_t'(c);
      end else if (pick < 55) begin
        hi = 6'($urandom);
        lo = 8'($urandom);
        chan_bytes.insert(chan_bytes.size(), {2'b01, hi});
        chan_bytes.insert(chan_bytes.size(), lo);
        chan_bytes.insert(chan_bytes.size(), 8'($urandom));
        total = total + rld_pkg::pixel_count_t'({hi, lo}) +
                rld_pkg::pixel_count_t'(rld_pkg::LEN_OFFSET);
      end else if (pick < 91) begin
        c = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 63);
        chan_bytes.insert(chan_bytes.size(), {2'b10, 6'(c)});
        repeat (c) chan_bytes.insert(chan_bytes.size(), 8'($urandom));
        total = total + rld_pkg::pixel_count_t'(c);
      end else if (pick < 93) begin
        // long literal kept near its minimum size
        lo = 8'($urandom_range(0, 7));
        chan_bytes.insert(chan_bytes.size(), {2'b11, 6'd0});
        chan_bytes.insert(chan_bytes.size(), lo);
        repeat (lo + 64) chan_bytes.insert(chan_bytes.size(), 8'($urandom));
        total = total + rld_pkg::pixel_count_t'(lo) +
                rld_pkg::pixel_count_t'(rld_pkg::LEN_OFFSET);
      end else begin
        chan_bytes.insert(chan_bytes.size(), 8'($urandom));
      end
    end
    // now and then cut the channel short
    if ($urandom_range(99) < 10) begin
      c = $urandom_range(1, chan_bytes.size());
      while (chan_bytes.size() > c) void'(chan_bytes.pop_back());
    end
  endtask

  // Receiver: random back-pressure, long hold on request
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_asks != stall_taken) begin
      stall_taken <= stall_asks;
      stall_left  <= HOLD_LEN;
      m_tready    <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res.pixel_value  = m_tdata[7:0];
      got_res.repeat_count = m_tdata[22:8];
      got_res.status       = m_tuser;
      got_res.channel_end  = m_tlast;
      if (pixel_results_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result: value %0d count %0d status %0d end %0d",
                 $time, got_res.pixel_value, got_res.repeat_count,
                 got_res.status, got_res.channel_end);
      end else begin
        want_res = pixel_results_q.pop_front();
        if (got_res !== want_res) begin
          err_count++;
          $display("%0t: mismatch: expected value %0d count %0d status %0d end %0d",
                   $time, want_res.pixel_value, want_res.repeat_count,
                   want_res.status, want_res.channel_end);
          $display("%0t:           actual value %0d count %0d status %0d end %0d",
                   $time, got_res.pixel_value, got_res.repeat_count,
                   got_res.status, got_res.channel_end);
        end
      end
    end
  end

  // Stimulus
  initial begin
    rld_pkg::pixel_count_t total;
    rld_pkg::pixel_count_t v;
    int unsigned           pick;
    int unsigned           ch;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = 8'h00;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;

    dec_phase   = DEC_CTRL;
    lit_token   = 1'b0;
    len_high    = '0;
    run_left    = '0;
    pixels_done = '0;
    first_err   = rld_pkg::ST_OK;
    exp_pixels  = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed table
    for (int i = 0; i < N_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) set_expected(directed_rows[i].cfg);
      else send_byte(directed_rows[i].data, directed_rows[i].last,
                     directed_rows[i].typed, directed_rows[i].want);
    end
    wait_idle();

    // Random channels until the beat budget is spent
    ch = 0;
    while (sent_beats < N_ITEMS) begin
      random_channel(total);
      pick = $urandom_range(99);
      if (pick >= 30) begin
        if (pick < 70) v = total;
        else if (pick < 78)
          v = (total > 40) ? total - rld_pkg::pixel_count_t'($urandom_range(1, 40)) : '0;
        else if (pick < 86) v = total + rld_pkg::pixel_count_t'($urandom_range(1, 3));
        else if (pick < 94) v = rld_pkg::pixel_count_t'({$urandom, $urandom});
        else v = PIX_MAX;
        set_expected(v);
      end
      quiet = (ch >= 15 && ch < 25);
      if (ch == 5 || ch == 32) stall_asks <= stall_asks + 1;
      for (int i = 0; i < chan_bytes.size(); i++)
        send_byte(chan_bytes[i], i == chan_bytes.size() - 1, 1'b0, NO_RES);
      ch++;
    end
    quiet = 1'b0;

    wait_idle();
    if (err_count == 0) begin
      $display("rle_run_literal_decoder_tb: done, clean");
    end else begin
      $display("rle_run_literal_decoder_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("rle_run_literal_decoder_tb: done, errors");
    $finish;
  end

endmodule
